/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, operation codes and cell types for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PRIO_BITS   = 8;
    localparam int TAG_BITS    = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // widths of the fixed result fields
    localparam int PRIO_PORT_W = 8;
    localparam int FILL_PORT_W = 5;

    // operation codes carried on func
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } entry_t;

    // broadcast control for every cell in the row
    typedef struct packed {
        logic enq;   // insert the new entry (queue not full)
        logic deq;   // remove the head entry (queue not empty)
    } cell_ctrl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, compares it against the new
// entry and loads from its left neighbor, its right neighbor or the input.
// ----------------------------------------------------------------------------
module spq_cell
(
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t     new_entry,
    input  logic                occupied,
    input  logic                left_take,
    input  spq_pkg::entry_t     left_entry,
    input  spq_pkg::entry_t     right_entry,
    output logic                take,
    output spq_pkg::entry_t     entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // claim the new entry when this slot is free or holds a later priority;
    // equal priorities stay ahead of the new one
    assign take  = !occupied || (new_entry.prio < entry_reg.prio);
    assign entry = entry_reg;

    // choose shift right, insert, shift left or hold
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (left_take)
                entry_next = left_entry;
            else if (take)
                entry_next = new_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    // hold the slot payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* hw/rtl/stable_priority_queue.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive func, prio_in and tag_in with start high; the command transfers at
//   the rising edge where start is high and busy is low. busy stays low, so
//   a command may be issued in every cycle.
//   func = enqueue inserts the entry behind all held entries of lower or
//   equal priority value; func = dequeue removes the head (lowest value).
//   Every command gives one result in the next cycle: result_valid is high for
//   exactly one cycle with done_ok, prio_out, tag_out, was_empty, was_full
//   and fill_level. The receiver cannot stall; it must take the result then.
//   Throughput is one command per cycle: every cell compares against the new
//   priority in parallel and shifts in the same edge, so the compare in each
//   cell and the entry count set the cycle.
//   A full-queue enqueue is dropped (was_full), an empty-queue dequeue
//   reports was_empty; neither changes the contents.
//   Reset (rst_n low, asynchronous) empties the queue and clears the result
//   strobe; slot contents are not cleared, only the count marks them.
// ----------------------------------------------------------------------------
module stable_priority_queue
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               func,
    input  logic [7:0]                         prio_in,
    input  logic [15:0]                        tag_in,
    output logic                               result_valid,
    output logic                               done_ok,
    output logic [7:0]                         prio_out,
    output logic [15:0]                        tag_out,
    output logic                               was_empty,
    output logic                               was_full,
    output logic [4:0]                         fill_level
);

    localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
    localparam int CW    = spq_pkg::COUNT_W;
    localparam int PB    = spq_pkg::PRIO_BITS;
    localparam int PW    = spq_pkg::PRIO_PORT_W;
    localparam int FW    = spq_pkg::FILL_PORT_W;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                accept;
    logic                is_full;
    logic                is_empty;
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::entry_t     new_entry;
    spq_pkg::entry_t     cell_entry [DEPTH];
    logic                cell_take  [DEPTH];
    logic [PB+PW-1:0]    prio_in_ext;
    logic [PB+PW-1:0]    head_prio_ext;
    logic [CW+FW-1:0]    fill_ext;

    logic                valid_reg;
    logic                ok_reg;
    logic [PW-1:0]       prio_reg;
    logic [15:0]         tag_reg;
    logic                empty_reg;
    logic                full_reg;
    logic [FW-1:0]       fill_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // decode the command against the fill count
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign ctrl.enq = accept && (func == spq_pkg::OP_ENQ) && !is_full;
    assign ctrl.deq = accept && (func == spq_pkg::OP_DEQ) && !is_empty;

    // cut the incoming priority to the stored width
    assign prio_in_ext   = {{PB{1'b0}}, prio_in};
    assign new_entry.prio = prio_in_ext[PB-1:0];
    assign new_entry.tag  = tag_in;

    // build the row of cells, head at index zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic            occ;
        logic            ltake;
        spq_pkg::entry_t lentry;
        spq_pkg::entry_t rentry;

        assign occ = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign ltake  = 1'b0;
            assign lentry = cell_entry[i];
        end
        else
        begin : g_body
            assign ltake  = cell_take[i-1];
            assign lentry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign rentry = cell_entry[i];
        end
        else
        begin : g_mid
            assign rentry = cell_entry[i+1];
        end

        spq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .occupied    (occ),
            .left_take   (ltake),
            .left_entry  (lentry),
            .right_entry (rentry),
            .take        (cell_take[i]),
            .entry       (cell_entry[i])
        );
    end

    // advance the fill count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
            count_next = count_reg + CW'(1);
        else if (ctrl.deq)
            count_next = count_reg - CW'(1);
    end

    assign head_prio_ext = {{PW{1'b0}}, cell_entry[0].prio};
    assign fill_ext      = {{FW{1'b0}}, count_next};

    // hold the fill count and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= accept;
        end
    end

    // register the result fields of each transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg    <= ctrl.enq || ctrl.deq;
            prio_reg  <= ctrl.deq ? head_prio_ext[PW-1:0] : '0;
            tag_reg   <= ctrl.deq ? cell_entry[0].tag : '0;
            empty_reg <= (func == spq_pkg::OP_DEQ) && is_empty;
            full_reg  <= (func == spq_pkg::OP_ENQ) && is_full;
            fill_reg  <= fill_ext[FW-1:0];
        end
    end

    assign result_valid = valid_reg;
    assign done_ok      = ok_reg;
    assign prio_out     = prio_reg;
    assign tag_out      = tag_reg;
    assign was_empty    = empty_reg;
    assign was_full     = full_reg;
    assign fill_level   = fill_reg;

endmodule

/* hw/rtl/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic        done_ok,
    input logic [7:0]  prio_out,
    input logic [15:0] tag_out,
    input logic        was_empty,
    input logic        was_full,
    input logic [4:0]  fill_level
);

    // every transfer yields exactly one result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> result_valid)
        else $error("command transfer gave no result");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !result_valid)
        else $error("result without a command transfer");

    // exactly one outcome per result
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $onehot({done_ok, was_empty, was_full}))
        else $error("result outcome flags inconsistent");

    // an empty dequeue leaves an empty queue and a zero payload
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && was_empty) |->
            (fill_level == 5'd0 && prio_out == 8'd0 && tag_out == 16'd0))
        else $error("empty dequeue result malformed");

endmodule

bind stable_priority_queue spq_checker u_spq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .done_ok      (done_ok),
    .prio_out     (prio_out),
    .tag_out      (tag_out),
    .was_empty    (was_empty),
    .was_full     (was_full),
    .fill_level   (fill_level)
);
